// ===== hdl/cidt_pkg.sv =====
// Shared types and constants of the correlation id table.
package cidt_pkg;

  localparam int unsigned TABLE_ENTRIES = 64;
  localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int unsigned CNT_W         = $clog2(TABLE_ENTRIES + 1);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned EXT_W    = 64;
  localparam int unsigned DEV_W    = 32;
  localparam int unsigned TS_W     = 64;
  localparam int unsigned USED_W   = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 3'd0,
    CMD_LOOKUP  = 3'd1,
    CMD_REPLACE = 3'd2,
    CMD_DELETE  = 3'd3,
    CMD_KERNEL  = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_RESOLVE,
    S_FINISH
  } state_e;

  // Kernel record: device, start and end time.
  typedef struct packed {
    logic [DEV_W-1:0] device;
    logic [TS_W-1:0]  start;
    logic [TS_W-1:0]  stop;
  } kern_t;

  // Everything an entry holds beside its key, kept in one memory word.
  typedef struct packed {
    logic [EXT_W-1:0] ext;
    kern_t            kern;
  } rec_t;

  localparam int unsigned REC_W = $bits(rec_t);

endpackage

// ===== hdl/cidt_ram.sv =====
// Simple dual-port RAM: one write port, one read port with registered read data.
module cidt_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== hdl/correlation_id_table_core.sv =====
// Top level of the correlation id table: scan sequencer, slot memories and result register.
//
// The table holds up to TABLE_ENTRIES entries keyed by a 32-bit correlation id.
// Commands arrive on the input channel (in_valid_i / in_ready_o) and each one
// produces exactly one result item on the output channel (out_valid_o /
// out_ready_i), in command order.
//
// Every command scans the whole key memory, one entry per cycle, to find the
// matching entry and the lowest free entry. From acceptance to its result
// being loaded, an item passes these steps in order: the key memory reads each
// entry, the last entry is compared, the key and valid bits are updated, and
// the record is read; the record memory is written as the result is loaded.
// The input is ready again in the cycle after the load, so a new command is
// only taken once the previous one has loaded its result.
//
// Results sit in an output register. A new command is accepted while a result
// is still waiting there; if the receiver stalls, the next finished command
// waits in its last step until the register is free.
//
// Reset clears the valid bits, the entry count and all control state. The
// memories themselves are not cleared; an entry's contents are only used while it is valid.
module correlation_id_table_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [cidt_pkg::CMD_W-1:0]      cmd_i,
  input  logic [cidt_pkg::KEY_W-1:0]      key_id_i,
  input  logic [cidt_pkg::EXT_W-1:0]      ext_id_in_i,
  input  logic [cidt_pkg::DEV_W-1:0]      device_in_i,
  input  logic [cidt_pkg::TS_W-1:0]       start_in_i,
  input  logic [cidt_pkg::TS_W-1:0]       end_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [cidt_pkg::STATUS_W-1:0]   status_o,
  output logic [cidt_pkg::EXT_W-1:0]      ext_id_out_o,
  output logic [cidt_pkg::DEV_W-1:0]      device_out_o,
  output logic [cidt_pkg::TS_W-1:0]       start_out_o,
  output logic [cidt_pkg::TS_W-1:0]       end_out_o,
  output logic [cidt_pkg::USED_W-1:0]     used_count_o
);

  import cidt_pkg::*;

  // Sequencer state.
  state_e state_q, state_d;

  // Scan address and compare stage. The key memory answers in the cycle after
  // the address, so the compare stage carries the index of the word it sees.
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             scan_last;

  // Command held for the length of its scan.
  logic [CMD_W-1:0] cmd_q;
  logic [KEY_W-1:0] key_q;
  logic [EXT_W-1:0] ext_q;
  kern_t            kern_in_q;

  // Scan results.
  logic             hit_fnd_q, hit_fnd_d;
  logic [IDX_W-1:0] hit_idx_q, hit_idx_d;
  logic             free_fnd_q, free_fnd_d;
  logic [IDX_W-1:0] free_idx_q, free_idx_d;

  // Table occupancy.
  logic [TABLE_ENTRIES-1:0] valid_q, valid_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  // Outcome of the command, kept until the result is loaded.
  status_e status_q, status_d;
  logic    lkp_hit_q, lkp_hit_d;

  // Output register.
  logic              out_valid_q, out_valid_d;
  logic              out_load;
  status_e           out_status_q;
  logic [EXT_W-1:0]  out_ext_q;
  kern_t             out_kern_q;
  logic [CNT_W-1:0]  out_cnt_q;

  // Memory ports.
  logic             key_we;
  logic [KEY_W-1:0] key_rdata;
  logic             rec_we;
  logic [IDX_W-1:0] rec_waddr;
  rec_t             rec_wdata;
  logic [REC_W-1:0] rec_rdata;
  rec_t             rec_rd;

  logic in_acc;
  logic do_insert;

  assign in_acc    = in_valid_i && in_ready_o;
  assign scan_last = (idx_q == IDX_W'(TABLE_ENTRIES - 1));
  assign rec_rd    = rec_t'(rec_rdata);

  // Keys of all entries. Read by the scan, written by an insert.
  cidt_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (KEY_W)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (free_idx_q),
    .wdata_i (key_q),
    .raddr_i (idx_q),
    .rdata_o (key_rdata)
  );

  // External id and kernel record of each entry. Read at the hit entry, so
  // the word is ready in the finish step for a lookup or a partial update.
  cidt_ram #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (REC_W)
  ) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (rec_we),
    .waddr_i (rec_waddr),
    .wdata_i (rec_wdata),
    .raddr_i (hit_idx_q),
    .rdata_o (rec_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        // After the last address, the compare stage still checks the last word.
        if (cmp_vld_q && (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1))) begin
          state_d = S_RESOLVE;
        end
      end
      S_RESOLVE: begin
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Scan address and the running search for the hit and the lowest free entry.
  always_comb begin
    idx_d      = idx_q;
    cmp_vld_d  = 1'b0;
    cmp_idx_d  = idx_q;
    hit_fnd_d  = hit_fnd_q;
    hit_idx_d  = hit_idx_q;
    free_fnd_d = free_fnd_q;
    free_idx_d = free_idx_q;

    if (in_acc) begin
      idx_d      = '0;
      hit_fnd_d  = 1'b0;
      free_fnd_d = 1'b0;
    end else if (state_q == S_SCAN) begin
      // Stop issuing once the last address has gone out.
      if (!(cmp_vld_q && (cmp_idx_q == IDX_W'(TABLE_ENTRIES - 1)))) begin
        cmp_vld_d = !(cmp_vld_q && scan_last && (cmp_idx_q == idx_q));
        if (!scan_last) begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
      if (cmp_vld_q) begin
        if (!hit_fnd_q && valid_q[cmp_idx_q] && (key_rdata == key_q)) begin
          hit_fnd_d = 1'b1;
          hit_idx_d = cmp_idx_q;
        end
        if (!free_fnd_q && !valid_q[cmp_idx_q]) begin
          free_fnd_d = 1'b1;
          free_idx_d = cmp_idx_q;
        end
      end
    end
  end

  // Actions: key write, occupancy and status, applied in the resolve step.
  always_comb begin
    key_we     = 1'b0;
    valid_d    = valid_q;
    cnt_d      = cnt_q;
    status_d   = status_q;
    lkp_hit_d  = lkp_hit_q;
    do_insert  = 1'b0;

    if (state_q == S_RESOLVE) begin
      status_d  = ST_ABSENT;
      lkp_hit_d = 1'b0;
      unique case (cmd_q)
        CMD_INSERT: begin
          if (hit_fnd_q) begin
            status_d = ST_DUP;
          end else if (!free_fnd_q) begin
            status_d = ST_FULL;
          end else begin
            do_insert           = 1'b1;
            key_we              = 1'b1;
            valid_d[free_idx_q] = 1'b1;
            cnt_d               = cnt_q + CNT_W'(1);
            status_d            = ST_OK;
          end
        end
        CMD_LOOKUP: begin
          if (hit_fnd_q) begin
            lkp_hit_d = 1'b1;
            status_d  = ST_OK;
          end
        end
        CMD_REPLACE: begin
          if (hit_fnd_q) begin
            status_d = ST_OK;
          end
        end
        CMD_DELETE: begin
          if (hit_fnd_q) begin
            valid_d[hit_idx_q] = 1'b0;
            if (cnt_q != '0) begin
              cnt_d = cnt_q - CNT_W'(1);
            end
            status_d = ST_OK;
          end
        end
        CMD_KERNEL: begin
          if (hit_fnd_q) begin
            status_d = ST_OK;
          end
        end
        default: begin
          status_d = ST_ABSENT;
        end
      endcase
    end
  end

  // Record write, done as the result is loaded. For a replace or kernel update the word
  // read at the hit entry is modified in the part the command changes and written back.
  always_comb begin
    rec_we    = 1'b0;
    rec_waddr = hit_idx_q;
    rec_wdata = rec_rd;
    if (out_load && (cmd_q == CMD_INSERT) && !hit_fnd_q && free_fnd_q) begin
      // A new entry starts with an empty kernel record.
      rec_we         = 1'b1;
      rec_waddr      = free_idx_q;
      rec_wdata.ext  = ext_q;
      rec_wdata.kern = '0;
    end else if (out_load && hit_fnd_q) begin
      case (cmd_q)
        CMD_REPLACE: begin
          rec_we        = 1'b1;
          rec_wdata.ext = ext_q;
        end
        CMD_KERNEL: begin
          rec_we         = 1'b1;
          rec_wdata.kern = kern_in_q;
        end
        default: begin
          rec_we = 1'b0;
        end
      endcase
    end
  end

  // Handshake outputs.
  always_comb begin
    in_ready_o  = (state_q == S_IDLE);
    out_load    = (state_q == S_FINISH) && (!out_valid_q || out_ready_i);
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cmp_vld_q   <= 1'b0;
      cmp_idx_q   <= '0;
      hit_fnd_q   <= 1'b0;
      hit_idx_q   <= '0;
      free_fnd_q  <= 1'b0;
      free_idx_q  <= '0;
      valid_q     <= '0;
      cnt_q       <= '0;
      status_q    <= ST_OK;
      lkp_hit_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cmp_vld_q   <= cmp_vld_d;
      cmp_idx_q   <= cmp_idx_d;
      hit_fnd_q   <= hit_fnd_d;
      hit_idx_q   <= hit_idx_d;
      free_fnd_q  <= free_fnd_d;
      free_idx_q  <= free_idx_d;
      valid_q     <= valid_d;
      cnt_q       <= cnt_d;
      status_q    <= status_d;
      lkp_hit_q   <= lkp_hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: the command under work and the result.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q            <= cmd_i;
      key_q            <= key_id_i;
      ext_q            <= ext_id_in_i;
      kern_in_q.device <= device_in_i;
      kern_in_q.start  <= start_in_i;
      kern_in_q.stop   <= end_in_i;
    end
    if (out_load) begin
      out_status_q <= status_q;
      out_cnt_q    <= cnt_q;
      // Record fields are only returned on a lookup hit.
      out_ext_q    <= lkp_hit_q ? rec_rd.ext : '0;
      out_kern_q   <= lkp_hit_q ? rec_rd.kern : '0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign ext_id_out_o = out_ext_q;
  assign device_out_o = out_kern_q.device;
  assign start_out_o  = out_kern_q.start;
  assign end_out_o    = out_kern_q.stop;
  assign used_count_o = USED_W'(out_cnt_q);

  // The entry count always matches the number of valid bits.
  a_cnt_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cnt_q) == $countones(valid_q)))
    else $error("entry count differs from number of valid entries");

  // An accepted insert grows the table by exactly one entry.
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESOLVE) && do_insert |=> (cnt_q == $past(cnt_q) + CNT_W'(1)))
    else $error("insert did not add one entry");

  // A duplicate-key status can only come from an insert.
  a_dup_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FINISH) && (status_q == ST_DUP) |-> (cmd_q == CMD_INSERT))
    else $error("duplicate status on a command other than insert");

  // An accepted command starts a clean scan, with no compare pending from before.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == S_SCAN) && !cmp_vld_q)
    else $error("scan did not start cleanly after a command was accepted");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the correlation id table core.
`timescale 1ns / 100ps

module tb;
  import cidt_pkg::*;

  // Command codes past the last defined one; the table must answer them with key absent.
  localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;

  localparam int POOL_KEYS    = 80;    // keys that random commands mostly address
  localparam int RANDOM_ITEMS = 400;
  localparam int QUIET_ITEMS  = 60;    // last items run without any idling
  localparam int HOLD_AT      = 150;   // accepted items before the long receiver hold
  localparam int LONG_HOLD    = 600;   // cycles of the long receiver hold
  localparam int TAIL_CYCLES  = 2 * (TABLE_ENTRIES + 3);
  localparam int LIMIT_NS     = 2_000_000;

  // One command as the sender offers it; a drain entry makes the sender wait
  // until every outstanding result has come back.
  typedef struct {
    logic             drain;
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    logic [EXT_W-1:0] ext;
    logic [DEV_W-1:0] dev;
    logic [TS_W-1:0]  t_start;
    logic [TS_W-1:0]  t_stop;
  } id_cmd_t;

  typedef struct {
    status_e           status;
    logic [EXT_W-1:0]  ext;
    logic [DEV_W-1:0]  dev;
    logic [TS_W-1:0]   t_start;
    logic [TS_W-1:0]   t_stop;
    logic [USED_W-1:0] used;
  } id_result_t;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [CMD_W-1:0]    cmd_i;
  logic [KEY_W-1:0]    key_id_i;
  logic [EXT_W-1:0]    ext_id_in_i;
  logic [DEV_W-1:0]    device_in_i;
  logic [TS_W-1:0]     start_in_i;
  logic [TS_W-1:0]     end_in_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [STATUS_W-1:0] status_o;
  logic [EXT_W-1:0]    ext_id_out_o;
  logic [DEV_W-1:0]    device_out_o;
  logic [TS_W-1:0]     start_out_o;
  logic [TS_W-1:0]     end_out_o;
  logic [USED_W-1:0]   used_count_o;

  correlation_id_table_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .cmd_i        (cmd_i),
    .key_id_i     (key_id_i),
    .ext_id_in_i  (ext_id_in_i),
    .device_in_i  (device_in_i),
    .start_in_i   (start_in_i),
    .end_in_i     (end_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .ext_id_out_o (ext_id_out_o),
    .device_out_o (device_out_o),
    .start_out_o  (start_out_o),
    .end_out_o    (end_out_o),
    .used_count_o (used_count_o)
  );

  // Shadow copy of the table, advanced once per accepted command.
  logic             tbl_valid [TABLE_ENTRIES];
  logic [KEY_W-1:0] tbl_key   [TABLE_ENTRIES];
  logic [EXT_W-1:0] tbl_ext   [TABLE_ENTRIES];
  logic [DEV_W-1:0] tbl_dev   [TABLE_ENTRIES];
  logic [TS_W-1:0]  tbl_start [TABLE_ENTRIES];
  logic [TS_W-1:0]  tbl_stop  [TABLE_ENTRIES];
  int               tbl_count;

  id_cmd_t          cmd_backlog[$];
  id_result_t       pending_results[$];
  logic [KEY_W-1:0] key_pool [POOL_KEYS];

  int   n_total;
  int   n_accepted;
  int   n_checked;
  int   n_errors;
  int   n_drains;
  int   st_seen [4];
  logic in_taken;
  int   idle_left;
  int   rdy_idle_left;
  int   hold_left;
  logic hold_done;

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Runs one command against the shadow table and returns the result it must produce.
  function automatic id_result_t apply_command(id_cmd_t c);
    id_result_t r;
    int         hit;
    int         free;
    r.status  = ST_ABSENT;
    r.ext     = '0;
    r.dev     = '0;
    r.t_start = '0;
    r.t_stop  = '0;
    hit  = -1;
    free = -1;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_key[i] == c.key && hit < 0) hit = i;
      if (!tbl_valid[i] && free < 0) free = i;
    end
    if (c.cmd == CMD_INSERT) begin
      if (hit >= 0) begin
        r.status = ST_DUP;
      end else if (free < 0) begin
        r.status = ST_FULL;
      end else begin
        // New entries land in the lowest free slot with a cleared kernel record.
        tbl_valid[free] = 1'b1;
        tbl_key[free]   = c.key;
        tbl_ext[free]   = c.ext;
        tbl_dev[free]   = '0;
        tbl_start[free] = '0;
        tbl_stop[free]  = '0;
        tbl_count++;
        r.status = ST_OK;
      end
    end else if (hit >= 0) begin
      case (c.cmd)
        CMD_LOOKUP: begin
          r.ext     = tbl_ext[hit];
          r.dev     = tbl_dev[hit];
          r.t_start = tbl_start[hit];
          r.t_stop  = tbl_stop[hit];
          r.status  = ST_OK;
        end
        CMD_REPLACE: begin
          tbl_ext[hit] = c.ext;
          r.status     = ST_OK;
        end
        CMD_DELETE: begin
          tbl_valid[hit] = 1'b0;
          if (tbl_count > 0) tbl_count--;
          r.status = ST_OK;
        end
        CMD_KERNEL: begin
          tbl_dev[hit]   = c.dev;
          tbl_start[hit] = c.t_start;
          tbl_stop[hit]  = c.t_stop;
          r.status       = ST_OK;
        end
        default: r.status = ST_ABSENT;
      endcase
    end
    r.used = USED_W'(tbl_count);
    return r;
  endfunction

  task automatic check_result(id_result_t w);
    if (status_o !== w.status) begin
      $error("status: expected %0d, actual %0d", w.status, status_o);
      n_errors++;
    end
    if (ext_id_out_o !== w.ext) begin
      $error("ext_id_out: expected %h, actual %h", w.ext, ext_id_out_o);
      n_errors++;
    end
    if (device_out_o !== w.dev) begin
      $error("device_out: expected %h, actual %h", w.dev, device_out_o);
      n_errors++;
    end
    if (start_out_o !== w.t_start) begin
      $error("start_out: expected %h, actual %h", w.t_start, start_out_o);
      n_errors++;
    end
    if (end_out_o !== w.t_stop) begin
      $error("end_out: expected %h, actual %h", w.t_stop, end_out_o);
      n_errors++;
    end
    if (used_count_o !== w.used) begin
      $error("used_count: expected %0d, actual %0d", w.used, used_count_o);
      n_errors++;
    end
  endtask

  task automatic push_cmd(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key, logic [EXT_W-1:0] ext,
                          logic [DEV_W-1:0] dev, logic [TS_W-1:0] t_start,
                          logic [TS_W-1:0] t_stop);
    id_cmd_t c;
    c.drain   = 1'b0;
    c.cmd     = cmd;
    c.key     = key;
    c.ext     = ext;
    c.dev     = dev;
    c.t_start = t_start;
    c.t_stop  = t_stop;
    cmd_backlog.push_back(c);
    n_total++;
  endtask

  task automatic push_drain();
    id_cmd_t c;
    c         = '{default: '0};
    c.drain   = 1'b1;
    cmd_backlog.push_back(c);
  endtask

  // One random command; the phase decides the mix so that the table fills up,
  // gets churned and is emptied again.
  task automatic push_random(int phase, int seq);
    logic [CMD_W-1:0] cmd;
    logic [KEY_W-1:0] key;
    int               pick;
    pick = $urandom_range(0, 99);
    key  = key_pool[$urandom_range(0, POOL_KEYS - 1)];
    case (phase)
      0: begin
        // Fill: walk the pool in order so that the table reaches its limit.
        if (pick < 88) begin
          cmd = CMD_INSERT;
          key = key_pool[seq % POOL_KEYS];
        end else begin
          cmd = (pick < 94) ? CMD_LOOKUP : CMD_KERNEL;
        end
      end
      1: begin
        if (pick < 5) cmd = CMD_LOOKUP;
        else if (pick < 80) cmd = CMD_DELETE;
        else cmd = (pick < 90) ? CMD_LOOKUP : CMD_INSERT;
      end
      default: begin
        if (pick < 5) cmd = CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
        else cmd = CMD_W'($urandom_range(CMD_INSERT, CMD_KERNEL));
      end
    endcase
    // A few keys from the whole range, which are almost always absent.
    if ($urandom_range(0, 15) == 0) key = $urandom();
    push_cmd(cmd, key, rand64(), $urandom(), rand64(), rand64());
  endtask

  always #2 clk_i = ~clk_i;

  // Reset, predictor state and the whole stimulus list.
  initial begin
    int phase;
    int seq;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    cmd_i       = '0;
    key_id_i    = '0;
    ext_id_in_i = '0;
    device_in_i = '0;
    start_in_i  = '0;
    end_in_i    = '0;
    out_ready_i = 1'b0;
    in_taken    = 1'b0;
    n_total     = 0;
    n_accepted  = 0;
    n_checked   = 0;
    n_errors    = 0;
    n_drains    = 0;
    idle_left     = 0;
    rdy_idle_left = 0;
    hold_left     = 0;
    hold_done     = 1'b0;
    tbl_count     = 0;
    for (int i = 0; i < 4; i++) st_seen[i] = 0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_key[i]   = '0;
      tbl_ext[i]   = '0;
      tbl_dev[i]   = '0;
      tbl_start[i] = '0;
      tbl_stop[i]  = '0;
    end
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_KEYS; i++) key_pool[i] = $urandom();

    // Directed part: every command on an empty table, the undefined codes,
    // duplicate insert, field extremes, delete and reinsert.
    push_cmd(CMD_LOOKUP,     '0, '0, '0, '0, '0);
    push_cmd(CMD_REPLACE,    '0, '1, '0, '0, '0);
    push_cmd(CMD_DELETE,     '1, '0, '0, '0, '0);
    push_cmd(CMD_KERNEL,     '0, '0, '1, '1, '1);
    push_cmd(CMD_RSVD_FIRST, '0, '0, '0, '0, '0);
    push_cmd(CMD_RSVD_LAST,  '1, '1, '1, '1, '1);
    push_cmd(CMD_INSERT,     '0, '1, '1, '1, '1);
    push_cmd(CMD_INSERT,     '1, '0, '0, '0, '0);
    push_cmd(CMD_INSERT,     '0, 64'h5a5a_5a5a_5a5a_5a5a, '0, '0, '0);
    push_cmd(CMD_LOOKUP,     '0, '0, '0, '0, '0);
    push_cmd(CMD_KERNEL,     '0, '0, '1, '1, '1);
    push_cmd(CMD_LOOKUP,     '0, '0, '0, '0, '0);
    push_cmd(CMD_REPLACE,    '1, '1, '0, '0, '0);
    push_cmd(CMD_LOOKUP,     '1, '0, '0, '0, '0);
    push_cmd(CMD_W'(CMD_RSVD_FIRST + 1), '1, '0, '0, '0, '0);
    push_cmd(CMD_DELETE,     '0, '0, '0, '0, '0);
    push_cmd(CMD_LOOKUP,     '0, '0, '0, '0, '0);
    push_cmd(CMD_DELETE,     '0, '0, '0, '0, '0);
    push_cmd(CMD_INSERT,     '0, '0, '0, '0, '0);
    push_cmd(CMD_LOOKUP,     '0, '0, '0, '0, '0);
    push_cmd(CMD_KERNEL,     '1, '0, '0, '0, '0);
    push_cmd(CMD_LOOKUP,     '1, '0, '0, '0, '0);
    push_drain();

    // Random part in phases: fill, churn, churn, empty, and round again.
    phase = 0;
    seq   = 0;
    while (n_total < 22 + RANDOM_ITEMS) begin
      for (int i = 0; i < 80; i++) begin
        push_random(phase % 2 == 0 ? (phase % 4 == 0 ? 0 : 2) : (phase % 4 == 1 ? 2 : 1), seq);
        seq++;
      end
      push_drain();
      phase++;
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  // Monitor: predicts each accepted command and checks each accepted result.
  always @(posedge clk_i) begin
    id_cmd_t seen;
    if (rst_ni) begin
      in_taken <= in_valid_i && in_ready_o;
      if (in_valid_i && in_ready_o) begin
        seen.drain   = 1'b0;
        seen.cmd     = cmd_i;
        seen.key     = key_id_i;
        seen.ext     = ext_id_in_i;
        seen.dev     = device_in_i;
        seen.t_start = start_in_i;
        seen.t_stop  = end_in_i;
        pending_results.push_back(apply_command(seen));
        n_accepted++;
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $error("result with no command outstanding: status %0d", status_o);
          n_errors++;
        end else begin
          check_result(pending_results.pop_front());
        end
        st_seen[status_o]++;
        n_checked++;
      end
    end
  end

  // Driver: offers the backlog in order, with idle bursts until the quiet tail.
  always @(negedge clk_i) begin
    logic    nxt_valid;
    id_cmd_t nxt;
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      nxt_valid = 1'b0;
      if (idle_left == 0 && n_accepted < n_total - QUIET_ITEMS && $urandom_range(0, 3) == 0)
        idle_left = $urandom_range(1, 12);
      if (idle_left > 0) begin
        idle_left--;
      end else if (cmd_backlog.size() > 0) begin
        if (cmd_backlog[0].drain) begin
          // Hold off until the table has answered everything sent so far.
          if (pending_results.size() == 0) begin
            void'(cmd_backlog.pop_front());
            n_drains++;
          end
        end else begin
          nxt         = cmd_backlog.pop_front();
          nxt_valid   = 1'b1;
          cmd_i       <= nxt.cmd;
          key_id_i    <= nxt.key;
          ext_id_in_i <= nxt.ext;
          device_in_i <= nxt.dev;
          start_in_i  <= nxt.t_start;
          end_in_i    <= nxt.t_stop;
        end
      end
      in_valid_i <= nxt_valid;
    end
  end

  // Receiver: random stall bursts, plus one long hold that backs the table up.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!hold_done && n_accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else if (n_accepted >= n_total - QUIET_ITEMS) begin
        out_ready_i <= 1'b1;
      end else if (rdy_idle_left > 0) begin
        rdy_idle_left--;
        out_ready_i <= 1'b0;
      end else if ($urandom_range(0, 5) == 0) begin
        rdy_idle_left = $urandom_range(0, 11);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // End of run: everything sent and answered, then a quiet tail for stray results.
  initial begin
    @(posedge rst_ni);
    while (cmd_backlog.size() > 0 || in_valid_i || pending_results.size() > 0)
      @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
      n_errors++;
    end
    $display("Run covered %0d commands and %0d results, with %0d drain pauses.",
             n_accepted, n_checked, n_drains);
    $display("Statuses: ok %0d, key absent %0d, duplicate %0d, table full %0d.",
             st_seen[ST_OK], st_seen[ST_ABSENT], st_seen[ST_DUP], st_seen[ST_FULL]);
    if (n_errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb failed");
    $finish;
  end

endmodule
